@@ rtl/sgps_pkg.sv @@
package sgps_pkg;

  // Default largest byte count of one descriptor.
  localparam int unsigned MAX_CHUNK_DEFAULT = 4194304;

  // Field widths.
  localparam int unsigned TOTAL_W  = 40;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned LEN_W    = 27;
  localparam int unsigned CNT_W    = 22;
  localparam int unsigned USED_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIMIT_W  = 16;

  // Descriptor counter carries one sticky bit above the reported width.
  localparam int unsigned DCNT_W = USED_W + 1;

  // Packed stream data widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 112;

  // Longest legal segment.
  localparam logic [LEN_W-1:0] SEG_LEN_MAX = 27'd67108864;

  // Reset value of the entry limit register.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // Input item kinds.
  localparam logic ACT_BEGIN = 1'b0;
  localparam logic ACT_SEG   = 1'b1;

  // Result item kinds.
  localparam logic KIND_DESC = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Request status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO_ENTRIES = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT        = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_begin;
    logic load_seg;
    logic emit_desc;
    logic mark_exhaust;
    logic emit_done;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic size_zero;
    logic final_chunk;
    logic at_limit;
    logic seg_last;
  } dp_status_t;

endpackage

@@ rtl/sgps_ctrl.sv @@
module sgps_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_action,
  output logic                 in_tready,
  input  sgps_pkg::dp_status_t st,
  output sgps_pkg::dp_cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_SPLIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Command decode and next state.
  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.load_begin = accept && (in_action == sgps_pkg::ACT_BEGIN);
        cmd.load_seg   = accept && (in_action == sgps_pkg::ACT_SEG);
        if (cmd.load_seg) begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (!st.size_zero) begin
          if (st.at_limit) begin
            // The table is full: latch the error and drop the rest.
            cmd.mark_exhaust = 1'b1;
          end else if (st.slot_free) begin
            cmd.emit_desc = 1'b1;
            if (st.final_chunk && !st.seg_last) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (st.seg_last) begin
          if (st.slot_free) begin
            cmd.emit_done = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/sgps_dp.sv @@
module sgps_dp #(
  parameter int unsigned MAX_CHUNK_BYTES = sgps_pkg::MAX_CHUNK_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sgps_pkg::dp_cmd_t               cmd,
  output sgps_pkg::dp_status_t            st,
  input  logic [sgps_pkg::TOTAL_W-1:0]    in_total_bytes,
  input  logic [sgps_pkg::ADDR_W-1:0]     in_seg_address,
  input  logic [sgps_pkg::LEN_W-1:0]      in_seg_length,
  input  logic                            in_last_segment,
  input  logic                            cfg_valid,
  input  logic [sgps_pkg::LIMIT_W-1:0]    cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [sgps_pkg::ADDR_W-1:0]     out_desc_address,
  output logic [sgps_pkg::CNT_W-1:0]      out_desc_count_minus_one,
  output logic [sgps_pkg::USED_W-1:0]     out_entries_used,
  output logic [sgps_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_last
);

  localparam logic [sgps_pkg::LEN_W-1:0] MaxChunk = sgps_pkg::LEN_W'(MAX_CHUNK_BYTES);

  // Request state.
  logic [sgps_pkg::LIMIT_W-1:0]  limit_r;
  logic [sgps_pkg::TOTAL_W-1:0]  rem_r;
  logic [sgps_pkg::DCNT_W-1:0]   cnt_r;
  logic [sgps_pkg::STATUS_W-1:0] err_r;

  // Segment being split.
  logic [sgps_pkg::ADDR_W-1:0]   addr_r;
  logic [sgps_pkg::LEN_W-1:0]    size_r;
  logic                          last_r;

  // Output register.
  logic                          out_valid_r;
  logic                          out_kind_r;
  logic [sgps_pkg::ADDR_W-1:0]   out_addr_r;
  logic [sgps_pkg::CNT_W-1:0]    out_cnt_r;
  logic [sgps_pkg::USED_W-1:0]   out_used_r;
  logic [sgps_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_last_r;

  logic                          active;
  logic                          bad_seg;
  logic [sgps_pkg::LEN_W-1:0]    seg_size;
  logic                          final_chunk;
  logic [sgps_pkg::LEN_W-1:0]    chunk;
  logic [sgps_pkg::DCNT_W-1:0]   cnt_inc;
  logic                          at_limit;
  logic                          next_at_limit;
  logic [sgps_pkg::STATUS_W-1:0] done_status;
  logic                          slot_free;

  // Segment checks against the state left by earlier items.
  assign active   = (err_r == sgps_pkg::ST_OK) && (rem_r != '0);
  assign bad_seg  = (in_seg_length > sgps_pkg::SEG_LEN_MAX) || in_seg_address[0];
  assign seg_size = ({13'd0, in_seg_length} < rem_r) ? in_seg_length
                                                      : rem_r[sgps_pkg::LEN_W-1:0];

  // Chunk cut and descriptor counting; the top counter bit sticks once set.
  assign final_chunk   = (size_r <= MaxChunk);
  assign chunk         = final_chunk ? size_r : MaxChunk;
  assign cnt_inc       = {cnt_r[sgps_pkg::USED_W] | (&cnt_r[sgps_pkg::USED_W-1:0]),
                          cnt_r[sgps_pkg::USED_W-1:0] + 16'd1};
  assign at_limit      = !cnt_r[sgps_pkg::USED_W] &&
                         (cnt_r[sgps_pkg::USED_W-1:0] == limit_r);
  assign next_at_limit = !cnt_inc[sgps_pkg::USED_W] &&
                         (cnt_inc[sgps_pkg::USED_W-1:0] == limit_r);

  // Final status of the request at its last segment.
  always_comb begin
    if (err_r != sgps_pkg::ST_OK) begin
      done_status = err_r;
    end else if (cnt_r == '0) begin
      done_status = sgps_pkg::ST_ZERO_ENTRIES;
    end else if (rem_r != '0) begin
      done_status = sgps_pkg::ST_SHORT;
    end else begin
      done_status = sgps_pkg::ST_OK;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  assign st.slot_free   = slot_free;
  assign st.size_zero   = (size_r == '0);
  assign st.final_chunk = final_chunk;
  assign st.at_limit    = at_limit;
  assign st.seg_last    = last_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sgps_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  // Request state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      cnt_r <= '0;
      err_r <= sgps_pkg::ST_OK;
    end else begin
      if (cmd.load_begin) begin
        rem_r <= in_total_bytes;
        cnt_r <= '0;
        err_r <= sgps_pkg::ST_OK;
      end else if (cmd.load_seg && active) begin
        if (bad_seg) begin
          err_r <= sgps_pkg::ST_MISALIGNED;
        end else begin
          rem_r <= rem_r - sgps_pkg::TOTAL_W'(seg_size);
        end
      end else if (cmd.emit_desc) begin
        cnt_r <= cnt_inc;
      end else if (cmd.mark_exhaust) begin
        err_r <= sgps_pkg::ST_EXHAUSTED;
      end else if (cmd.emit_done) begin
        err_r <= done_status;
      end
    end
  end

  // Segment registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else begin
      if (cmd.load_seg) begin
        addr_r <= in_seg_address;
        last_r <= in_last_segment;
        size_r <= (active && !bad_seg) ? seg_size : '0;
      end else if (cmd.emit_desc) begin
        addr_r <= addr_r + sgps_pkg::ADDR_W'(chunk);
        size_r <= size_r - chunk;
      end else if (cmd.mark_exhaust) begin
        size_r <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_desc || cmd.emit_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_desc) begin
      out_kind_r   <= sgps_pkg::KIND_DESC;
      out_addr_r   <= addr_r;
      out_cnt_r    <= sgps_pkg::CNT_W'(chunk - 27'd1);
      out_used_r   <= cnt_inc[sgps_pkg::USED_W-1:0];
      out_status_r <= sgps_pkg::ST_OK;
      out_last_r   <= !last_r && (final_chunk || next_at_limit);
    end else if (cmd.emit_done) begin
      out_kind_r   <= sgps_pkg::KIND_DONE;
      out_addr_r   <= '0;
      out_cnt_r    <= '0;
      out_used_r   <= cnt_r[sgps_pkg::USED_W-1:0];
      out_status_r <= done_status;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_kind                 = out_kind_r;
  assign out_desc_address         = out_addr_r;
  assign out_desc_count_minus_one = out_cnt_r;
  assign out_entries_used         = out_used_r;
  assign out_status               = out_status_r;
  assign out_last                 = out_last_r;

endmodule

@@ rtl/scatter_gather_prd_splitter.sv @@
// Splits scatter-gather segments into descriptor-table entries. A begin
// item (in_tuser 0) loads the total transfer length. A segment item
// (in_tuser 1) is loaded in the idle state and then cut into descriptors of
// at most MAX_CHUNK_BYTES bytes; the controller cuts one chunk per cycle
// into the single result register while that register is free. When the
// entry limit stops a segment, a further step latches the error. A last
// segment then issues its completion. Any other segment that ends without
// issuing its final descriptor, including one that yields no descriptor at
// all, takes a further step to return to idle. Every descriptor and
// completion also waits while the result register still holds a result the
// output side has not taken. A new item is taken once the previous segment
// has been fully split. The user must write the entry limit on the cfg port
// only between requests; the block itself does not enforce this. The limit
// resets to 65535.
module scatter_gather_prd_splitter #(
  parameter int unsigned MAX_CHUNK_BYTES = sgps_pkg::MAX_CHUNK_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // total_bytes[39:0], seg_address[103:40], seg_length[130:104], zero pad
  input  logic [sgps_pkg::IN_DATA_W-1:0]    in_tdata,
  // action
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // desc_address[63:0], desc_count_minus_one[85:64], entries_used[101:86],
  // status[104:102], zero pad
  output logic [sgps_pkg::OUT_DATA_W-1:0]   out_tdata,
  // kind
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgps_pkg::LIMIT_W-1:0]      cfg_data
);

  sgps_pkg::dp_cmd_t              cmd;
  sgps_pkg::dp_status_t           st;
  logic [sgps_pkg::ADDR_W-1:0]    desc_address;
  logic [sgps_pkg::CNT_W-1:0]     desc_count_minus_one;
  logic [sgps_pkg::USED_W-1:0]    entries_used;
  logic [sgps_pkg::STATUS_W-1:0]  status;

  assign cfg_ready = 1'b1;

  // Request sequencing.
  sgps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Length tracking, chunk cutting and result register.
  sgps_dp #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .st                       (st),
    .in_total_bytes           (in_tdata[39:0]),
    .in_seg_address           (in_tdata[103:40]),
    .in_seg_length            (in_tdata[130:104]),
    .in_last_segment          (in_tlast),
    .cfg_valid                (cfg_valid),
    .cfg_data                 (cfg_data),
    .out_valid                (out_tvalid),
    .out_ready                (out_tready),
    .out_kind                 (out_tuser),
    .out_desc_address         (desc_address),
    .out_desc_count_minus_one (desc_count_minus_one),
    .out_entries_used         (entries_used),
    .out_status               (status),
    .out_last                 (out_tlast)
  );

  // Pack the result fields.
  assign out_tdata = {7'd0, status, entries_used, desc_count_minus_one, desc_address};

  // A completion always closes the results of its segment.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == sgps_pkg::KIND_DONE)) |-> out_tlast)
    else $error("completion result without last flag");

  // Descriptors carry no status.
  a_desc_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == sgps_pkg::KIND_DESC)) |->
      (out_tdata[104:102] == sgps_pkg::ST_OK))
    else $error("descriptor with nonzero status");

  // A segment request is split before another request is taken.
  a_seg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == sgps_pkg::ACT_SEG)) |=> !in_tready)
    else $error("input taken while a segment is being split");

endmodule
